>>> hdl/bes_pkg.sv
`timescale 1ns / 1ps

package bes_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned CFG_T_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned EXPR_W    = 3;
	// The remainder stays below the divisor, which is at most 2^CFG_T_W.
	localparam int unsigned REM_W     = CFG_T_W;
	localparam int unsigned DIV_W     = CFG_T_W + 1;
	localparam int unsigned BIT_CNT_W = $clog2(WORD_W);

	localparam logic [WORD_W-1:0] SEED_FALLBACK = 32'h2545F491;

	localparam int unsigned XS_A = 13;
	localparam int unsigned XS_B = 17;
	localparam int unsigned XS_C = 5;

	localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SPLASH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLINK   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_MAX = 3'd4;

	localparam logic [CFG_T_W-1:0] SPLASH_RST  = 16'd1500;
	localparam logic [CFG_T_W-1:0] BLINK_RST   = 16'd150;
	localparam logic [CFG_T_W-1:0] GAP_MIN_RST = 16'd2000;
	localparam logic [CFG_T_W-1:0] GAP_MAX_RST = 16'd6000;

	typedef enum logic [EXPR_W-1:0] {
		EXPR_IDLE   = 3'd0,
		EXPR_BLINK  = 3'd1,
		EXPR_PAUSED = 3'd2,
		EXPR_SPLASH = 3'd3,
		EXPR_ERROR  = 3'd4
	} expr_t;

	typedef struct packed {
		logic load_in;
		logic decide;
		logic gen_step;
		logic div_init;
		logic div_step;
		logic add_deadline;
		logic check;
		logic emit;
	} bes_cmd_t;

	typedef struct packed {
		logic       is_start;
		logic [1:0] plans;
		logic       defer;
		logic       out_free;
	} bes_sts_t;

	function automatic logic [WORD_W-1:0] xorshift_step(input logic [WORD_W-1:0] x);
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
		a = x ^ (x << XS_A);
		b = a ^ (a >> XS_B);
		return b ^ (b << XS_C);
	endfunction

	// A deadline counts as reached when now is less than half the time range past it.
	function automatic logic deadline_passed(input logic [WORD_W-1:0] now,
		input logic [WORD_W-1:0] when);
		logic [WORD_W-1:0] diff;
		diff = now - when;
		return ~diff[WORD_W-1];
	endfunction

endpackage

>>> hdl/bes_if.sv
`timescale 1ns / 1ps

interface bes_in_if import bes_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic [WORD_W-1:0] now_time;
	logic              storage_ok;
	logic              is_playing;

	modport source (output valid, op, now_time, storage_ok, is_playing, input ready);
	modport sink (input valid, op, now_time, storage_ok, is_playing, output ready);
endinterface

interface bes_out_if import bes_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [EXPR_W-1:0] expression;

	modport source (output valid, expression, input ready);
	modport sink (input valid, expression, output ready);
endinterface

interface bes_cfg_if import bes_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WORD_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/blink_expression_sequencer_unit.sv
`timescale 1ns / 1ps

// Channel  Dir  Words                                       Handshake
// in_ch    in   op, now_time, storage_ok, is_playing        valid/ready
// out_ch   out  expression                                  valid/ready
// cfg_ch   in   index, data (seed, splash, blink, gap min/max) valid/ready, ready always high
//
// One word is worked on at a time. After acceptance an item is decided; then the generator
// advances once or twice, the 32-step bit-serial remainder by the gap span sets a new gap, the
// deadline is added, and the blink check runs once more when it waits for that new deadline.
// An already decided item goes straight to its result. A start word gives no result.
// Reset loads the register defaults and the fallback seed. A stalled result waits in the
// output register; the next word is still taken, and its result waits until that moves.

module blink_expression_sequencer_unit import bes_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	bes_in_if.sink  in_ch,
	bes_out_if.source out_ch,
	bes_cfg_if.sink cfg_ch
);

	bes_cmd_t cmd;
	bes_sts_t sts;

	assign cfg_ch.ready = 1'b1;

	bes_controller u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bes_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (in_ch.op),
		.now_time   (in_ch.now_time),
		.storage_ok (in_ch.storage_ok),
		.is_playing (in_ch.is_playing),
		.cfg_we     (cfg_ch.valid),
		.cfg_index  (cfg_ch.index),
		.cfg_data   (cfg_ch.data),
		.out_ready  (out_ch.ready),
		.out_valid  (out_ch.valid),
		.expression (out_ch.expression)
	);

	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !sts.is_start)
		else $error("start word produced a result");

	a_decide_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |=> cmd.decide)
		else $error("accepted word not decided in the next cycle");

	a_step_before_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_init |-> $past(cmd.gen_step))
		else $error("remainder started without a fresh generator step");

	a_expr_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> (out_ch.expression == EXPR_IDLE || out_ch.expression == EXPR_BLINK
			|| out_ch.expression == EXPR_PAUSED || out_ch.expression == EXPR_SPLASH
			|| out_ch.expression == EXPR_ERROR))
		else $error("expression code out of range");

endmodule

>>> hdl/bes_datapath.sv
`timescale 1ns / 1ps

module bes_datapath import bes_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  bes_cmd_t             cmd,
	output bes_sts_t             sts,
	input  logic                 op,
	input  logic [WORD_W-1:0]    now_time,
	input  logic                 storage_ok,
	input  logic                 is_playing,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [EXPR_W-1:0]    expression
);

	logic [WORD_W-1:0]  seed_q;
	logic [CFG_T_W-1:0] splash_time_q;
	logic [CFG_T_W-1:0] blink_time_q;
	logic [CFG_T_W-1:0] gap_min_q;
	logic [CFG_T_W-1:0] gap_max_q;

	logic               op_q;
	logic [WORD_W-1:0]  now_q;
	logic               ok_q;
	logic               playing_q;

	logic [WORD_W-1:0]  random_q;
	logic [WORD_W-1:0]  next_q;
	logic [WORD_W-1:0]  blink_end_q;
	logic [WORD_W-1:0]  splash_end_q;
	logic               splash_on_q;
	logic               blink_on_q;
	logic               prev_ok_q;
	expr_t              expr_q;
	logic               defer_q;

	logic [WORD_W-1:0]  dividend_q;
	logic [REM_W-1:0]   rem_q;
	logic [DIV_W-1:0]   divisor_q;

	logic               out_valid_q;
	logic [EXPR_W-1:0]  out_expr_q;

	logic               rise;
	logic               splash_act;
	logic               splash_over;
	logic               d_splash_on;
	logic               d_blink_on;
	logic               d_blink_set;
	logic               d_defer;
	logic [1:0]         d_plans;
	expr_t              d_expr;
	logic [CFG_T_W-1:0] gap_hi;
	logic [DIV_W-1:0]   shifted;
	logic [WORD_W-1:0]  blink_end_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q        <= '0;
			splash_time_q <= SPLASH_RST;
			blink_time_q  <= BLINK_RST;
			gap_min_q     <= GAP_MIN_RST;
			gap_max_q     <= GAP_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SEED:    seed_q        <= cfg_data;
				CFG_SPLASH:  splash_time_q <= cfg_data[CFG_T_W-1:0];
				CFG_BLINK:   blink_time_q  <= cfg_data[CFG_T_W-1:0];
				CFG_GAP_MIN: gap_min_q     <= cfg_data[CFG_T_W-1:0];
				CFG_GAP_MAX: gap_max_q     <= cfg_data[CFG_T_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q      <= op;
			now_q     <= now_time;
			ok_q      <= storage_ok;
			playing_q <= is_playing;
		end
	end

	assign blink_end_new = now_q + WORD_W'(blink_time_q);

	always_comb begin
		rise        = ok_q & ~prev_ok_q;
		splash_act  = splash_on_q | rise;
		// A splash that starts now has ended already only when its length is zero.
		splash_over = rise ? (splash_time_q == '0) : deadline_passed(now_q, splash_end_q);
		d_splash_on = splash_on_q;
		d_blink_on  = blink_on_q;
		d_blink_set = 1'b0;
		d_defer     = 1'b0;
		d_plans     = 2'd0;
		d_expr      = EXPR_IDLE;
		if (op_q) begin
			d_plans = 2'd1;
		end else if (!ok_q) begin
			d_splash_on = 1'b0;
			d_blink_on  = 1'b0;
			d_plans     = 2'd1;
			d_expr      = EXPR_ERROR;
		end else if (splash_act && !splash_over) begin
			d_splash_on = 1'b1;
			d_plans     = 2'd1;
			d_expr      = EXPR_SPLASH;
		end else begin
			d_splash_on = 1'b0;
			if (!playing_q) begin
				d_blink_on = 1'b0;
				d_plans    = splash_act ? 2'd2 : 2'd1;
				d_expr     = EXPR_PAUSED;
			end else if (blink_on_q) begin
				if (deadline_passed(now_q, blink_end_q)) begin
					d_blink_on = 1'b0;
					d_plans    = splash_act ? 2'd2 : 2'd1;
				end else begin
					d_plans = splash_act ? 2'd1 : 2'd0;
					d_expr  = EXPR_BLINK;
				end
			end else if (splash_act) begin
				// The blink check must see the deadline that the splash end plans.
				d_plans = 2'd1;
				d_defer = 1'b1;
			end else if (deadline_passed(now_q, next_q)) begin
				d_blink_on  = 1'b1;
				d_blink_set = 1'b1;
				d_expr      = EXPR_BLINK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			random_q     <= SEED_FALLBACK;
			next_q       <= '0;
			blink_end_q  <= '0;
			splash_end_q <= '0;
			splash_on_q  <= 1'b0;
			blink_on_q   <= 1'b0;
			prev_ok_q    <= 1'b0;
			expr_q       <= EXPR_IDLE;
			defer_q      <= 1'b0;
		end else if (cmd.decide) begin
			expr_q  <= d_expr;
			defer_q <= d_defer;
			if (op_q) begin
				random_q     <= (seed_q != '0) ? seed_q : SEED_FALLBACK;
				next_q       <= '0;
				blink_end_q  <= '0;
				splash_end_q <= '0;
				splash_on_q  <= 1'b0;
				blink_on_q   <= 1'b0;
				prev_ok_q    <= 1'b0;
			end else begin
				prev_ok_q   <= ok_q;
				splash_on_q <= d_splash_on;
				blink_on_q  <= d_blink_on;
				if (rise) begin
					splash_end_q <= now_q + WORD_W'(splash_time_q);
				end
				if (d_blink_set) begin
					blink_end_q <= blink_end_new;
				end
			end
		end else if (cmd.gen_step) begin
			random_q <= xorshift_step(random_q);
		end else if (cmd.add_deadline) begin
			next_q <= now_q + WORD_W'(gap_min_q) + WORD_W'(rem_q);
		end else if (cmd.check) begin
			if (deadline_passed(now_q, next_q)) begin
				blink_on_q  <= 1'b1;
				blink_end_q <= blink_end_new;
				expr_q      <= EXPR_BLINK;
			end
		end
	end

	assign gap_hi  = (gap_max_q < gap_min_q) ? gap_min_q : gap_max_q;
	assign shifted = {rem_q, dividend_q[WORD_W-1]};

	// Restoring remainder, one dividend bit per step, most significant first.
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			dividend_q <= random_q;
			rem_q      <= '0;
			divisor_q  <= DIV_W'(gap_hi - gap_min_q) + DIV_W'(1);
		end else if (cmd.div_step) begin
			dividend_q <= {dividend_q[WORD_W-2:0], 1'b0};
			if (shifted >= divisor_q) begin
				rem_q <= REM_W'(shifted - divisor_q);
			end else begin
				rem_q <= shifted[REM_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_expr_q <= expr_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign expression = out_expr_q;

	assign sts.is_start = op_q;
	assign sts.plans    = d_plans;
	assign sts.defer    = defer_q;
	assign sts.out_free = ~out_valid_q | out_ready;

endmodule

>>> hdl/bes_controller.sv
`timescale 1ns / 1ps

module bes_controller import bes_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  bes_sts_t sts,
	output bes_cmd_t cmd
);

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_DECIDE = 8'b0000_0010,
		S_STEP   = 8'b0000_0100,
		S_LOAD   = 8'b0000_1000,
		S_DIV    = 8'b0001_0000,
		S_ADD    = 8'b0010_0000,
		S_CHECK  = 8'b0100_0000,
		S_EMIT   = 8'b1000_0000
	} state_t;

	state_t               state_q;
	state_t               state_d;
	logic [1:0]           plans_q;
	logic [BIT_CNT_W-1:0] bit_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = (sts.plans == 2'd0) ? S_EMIT : S_STEP;
			end
			S_STEP: begin
				cmd.gen_step = 1'b1;
				state_d      = (plans_q == 2'd1) ? S_LOAD : S_STEP;
			end
			S_LOAD: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (bit_q == BIT_CNT_W'(WORD_W - 1)) begin
					state_d = S_ADD;
				end
			end
			S_ADD: begin
				cmd.add_deadline = 1'b1;
				if (sts.defer) begin
					state_d = S_CHECK;
				end else if (sts.is_start) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_EMIT;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				state_d   = S_EMIT;
			end
			S_EMIT: begin
				cmd.emit = sts.out_free;
				if (sts.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			plans_q <= 2'd0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.decide) begin
				plans_q <= sts.plans;
			end else if (cmd.gen_step) begin
				plans_q <= plans_q - 2'd1;
			end
			if (cmd.div_init) begin
				bit_q <= '0;
			end else if (cmd.div_step) begin
				bit_q <= bit_q + BIT_CNT_W'(1);
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);

endmodule
